### src/bpab_pkg.sv
package bpab_pkg;

  localparam int unsigned WtW   = 17;
  localparam int unsigned AwW   = 25;
  localparam int unsigned AsumW = 27;
  localparam int unsigned CaW   = 16;
  localparam int unsigned WqW   = 13;
  localparam int unsigned TermW = 29;
  localparam int unsigned NumW  = 30;
  localparam int unsigned DivW  = 21;
  localparam int unsigned QW    = 8;

  localparam logic CFG_BILINEAR_ON = 1'b0;
  localparam logic CFG_ALPHA_FLOOR = 1'b1;
  localparam logic [7:0] ALPHA_FLOOR_RST = 8'd10;

  typedef struct packed {
    logic [31:0] top_left;
    logic [31:0] top_right;
    logic [31:0] bottom_left;
    logic [31:0] bottom_right;
    logic [7:0]  weight_x;
    logic [7:0]  weight_y;
    logic [15:0] background;
  } in_word_t;

  typedef struct packed {
    logic [15:0] pixel_out;
    logic        write_enable;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  alpha;
    logic [31:0] top_left;
    logic [15:0] background;
  } side_t;

  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

  function automatic logic [7:0] chan8(logic [31:0] px, logic [1:0] k);
    return px[8*k +: 8];
  endfunction

endpackage

### src/bpab_front.sv
module bpab_front import bpab_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pipe_ctl_t            ctl_i,
  input  in_word_t             word_i,
  output logic                 vld_o,
  output logic [2:0][NumW-1:0] num_o,
  output side_t                side_o
);

  logic [3:0][31:0] px;
  logic [8:0]       wxi, wyi, wx9, wy9;
  logic [17:0]      p0, p1, p2, p3;

  logic [3:0][WtW-1:0] w_q;
  logic [3:0][31:0]    px1_q;
  logic [15:0]         bg1_q;
  logic                vld1_q;

  logic [3:0][AwW-1:0]      aw_q;
  logic [3:0][2:0][CaW-1:0] ca_q;
  logic [3:0][WqW-1:0]      wq_q;
  logic [31:0]              tl2_q;
  logic [15:0]              bg2_q;
  logic                     vld2_q;

  logic [AsumW-1:0]           asum;
  logic [7:0]                 a_d;
  logic [2:0][3:0][TermW-1:0] term_q;
  logic [7:0]                 a3_q;
  logic [31:0]                tl3_q;
  logic [15:0]                bg3_q;
  logic                       vld3_q;

  logic [2:0][NumW-1:0] num_q;
  side_t                side_q;
  logic                 vld4_q;

  assign px  = {word_i.bottom_right, word_i.bottom_left, word_i.top_right, word_i.top_left};
  assign wx9 = {1'b0, word_i.weight_x};
  assign wy9 = {1'b0, word_i.weight_y};
  assign wxi = 9'd256 - wx9;
  assign wyi = 9'd256 - wy9;
  assign p0  = wxi * wyi;
  assign p1  = wx9 * wyi;
  assign p2  = wxi * wy9;
  assign p3  = wx9 * wy9;

  // weights
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      w_q   <= {p3[WtW-1:0], p2[WtW-1:0], p1[WtW-1:0], p0[WtW-1:0]};
      px1_q <= px;
      bg1_q <= word_i.background;
    end
  end

  // alpha times weight, colour times alpha
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      for (int i = 0; i < 4; i++) begin
        aw_q[i] <= AwW'(chan8(px1_q[i], 2'd3)) * AwW'(w_q[i]);
        wq_q[i] <= w_q[i][WtW-1:4];
        for (int k = 0; k < 3; k++) begin
          ca_q[i][k] <= chan8(px1_q[i], 2'(k)) * chan8(px1_q[i], 2'd3);
        end
      end
      tl2_q <= px1_q[0];
      bg2_q <= bg1_q;
    end
  end

  always_comb begin
    asum = AsumW'(aw_q[0]) + AsumW'(aw_q[1]) + AsumW'(aw_q[2]) + AsumW'(aw_q[3]);
    a_d  = (asum[AsumW-1:24] != '0) ? 8'hFF : asum[23:16];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 4; i++) begin
          term_q[k][i] <= TermW'(ca_q[i][k]) * TermW'(wq_q[i]);
        end
      end
      a3_q  <= a_d;
      tl3_q <= tl2_q;
      bg3_q <= bg2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      for (int k = 0; k < 3; k++) begin
        num_q[k] <= NumW'(term_q[k][0]) + NumW'(term_q[k][1])
                  + NumW'(term_q[k][2]) + NumW'(term_q[k][3]);
      end
      side_q <= '{alpha: a3_q, top_left: tl3_q, background: bg3_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else if (ctl_i.en) begin
      vld1_q <= ctl_i.vld;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  assign vld_o  = vld4_q;
  assign num_o  = num_q;
  assign side_o = side_q;

endmodule

### src/bpab_div.sv
module bpab_div import bpab_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pipe_ctl_t            ctl_i,
  input  logic [2:0][NumW-1:0] num_i,
  input  side_t                side_i,
  output logic                 vld_o,
  output logic [2:0][QW-1:0]   q_o,
  output logic [2:0]           ovf_o,
  output side_t                side_o
);

  logic [QW-1:0][2:0][NumW-1:0] rem_q;
  logic [QW-1:0][2:0][QW-1:0]   quo_q;
  logic [QW-1:0][2:0]           ovf_q;
  side_t [QW-1:0]               side_q;
  logic [QW-1:0]                vld_q;

  logic [QW-1:0][2:0][NumW-1:0] rem_in;
  logic [QW-1:0][2:0][QW-1:0]   quo_in;
  logic [QW-1:0][2:0]           ovf_in;
  side_t [QW-1:0]               side_in;
  logic [QW-1:0]                vld_in;

  // one quotient bit per stage, msb first
  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [DivW-1:0] dv;
    logic [NumW-1:0] dsh;
    logic [2:0]      ge;

    if (j == 0) begin : g_first
      logic [NumW-1:0] dtop;
      assign dtop = NumW'({side_i.alpha, 12'h000} + 21'd1) << QW;
      for (genvar k = 0; k < 3; k++) begin : g_ch
        assign rem_in[j][k] = num_i[k];
        assign quo_in[j][k] = '0;
        assign ovf_in[j][k] = num_i[k] >= dtop;
      end
      assign side_in[j] = side_i;
      assign vld_in[j]  = ctl_i.vld;
    end else begin : g_next
      assign rem_in[j]  = rem_q[j-1];
      assign quo_in[j]  = quo_q[j-1];
      assign ovf_in[j]  = ovf_q[j-1];
      assign side_in[j] = side_q[j-1];
      assign vld_in[j]  = vld_q[j-1];
    end

    assign dv  = {side_in[j].alpha, 12'h000} + 21'd1;
    assign dsh = NumW'(dv) << (QW - 1 - j);

    for (genvar k = 0; k < 3; k++) begin : g_ge
      assign ge[k] = rem_in[j][k] >= dsh;
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        for (int k = 0; k < 3; k++) begin
          rem_q[j][k] <= ge[k] ? rem_in[j][k] - dsh : rem_in[j][k];
          quo_q[j][k] <= quo_in[j][k] | (QW'(ge[k]) << (QW - 1 - j));
        end
        ovf_q[j]  <= ovf_in[j];
        side_q[j] <= side_in[j];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[j] <= vld_in[j];
      end
    end
  end

  assign vld_o  = vld_q[QW-1];
  assign q_o    = quo_q[QW-1];
  assign ovf_o  = ovf_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

### src/bpab_blend.sv
module bpab_blend import bpab_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pipe_ctl_t          ctl_i,
  input  logic [2:0][QW-1:0] q_i,
  input  logic [2:0]         ovf_i,
  input  side_t              side_i,
  input  logic               bilinear_on_i,
  input  logic [7:0]         alpha_floor_i,
  output logic               vld_o,
  output out_word_t          word_o
);

  logic [2:0][7:0] col_d;
  logic [7:0]      alpha;
  logic [9:0]      a3x;

  logic [2:0][7:0] col_q;
  logic [7:0]      a_q;
  logic            we1_q;
  logic [15:0]     bg1_q;
  logic            vld1_q;

  logic [2:0][7:0]  bgx;
  logic [2:0][15:0] pc_q;
  logic [2:0][15:0] pb_q;
  logic             we2_q;
  logic [15:0]      bg2_q;
  logic             vld2_q;

  logic [2:0][16:0] x;
  logic [2:0][16:0] y;
  out_word_t        word_d;
  out_word_t        word_q;
  logic             vld3_q;

  always_comb begin
    alpha = bilinear_on_i ? side_i.alpha : chan8(side_i.top_left, 2'd3);
    a3x   = {alpha, 1'b0} + {2'b00, alpha};
    for (int k = 0; k < 3; k++) begin
      if (!bilinear_on_i) begin
        col_d[k] = chan8(side_i.top_left, 2'(k));
      end else if (side_i.alpha == 8'd0) begin
        col_d[k] = 8'd0;
      end else if (ovf_i[k]) begin
        col_d[k] = 8'hFF;
      end else begin
        col_d[k] = q_i[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      col_q <= col_d;
      a_q   <= a3x[9:2];
      we1_q <= a3x[9:2] >= alpha_floor_i;
      bg1_q <= side_i.background;
    end
  end

  assign bgx[0] = {bg1_q[15:11], 3'b000};
  assign bgx[1] = {bg1_q[10:5], 2'b00};
  assign bgx[2] = {bg1_q[4:0], 3'b000};

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      for (int k = 0; k < 3; k++) begin
        pc_q[k] <= col_q[k] * a_q;
        pb_q[k] <= bgx[k] * (8'hFF - a_q);
      end
      we2_q <= we1_q;
      bg2_q <= bg1_q;
    end
  end

  // divide by 255, exact below 65535
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      x[k] = {1'b0, pc_q[k]} + {1'b0, pb_q[k]};
      y[k] = (x[k] + 17'd1 + {8'd0, x[k][16:8]}) >> 8;
    end
    word_d.write_enable = we2_q;
    word_d.pixel_out    = we2_q ? {y[0][7:3], y[1][7:2], y[2][7:3]} : bg2_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      word_q <= word_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (ctl_i.en) begin
      vld1_q <= ctl_i.vld;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  assign vld_o  = vld3_q;
  assign word_o = word_q;

endmodule

### src/bilinear_premult_alpha_blend_rgb565_unit.sv
// channel  direction  signals
// in       input      in_valid_i, in_stall_o, in_word_i
// out      output     out_valid_o, out_stall_i, out_word_o
// cfg      input      cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
//
// one word per cycle unless a held output word stalls the pipeline; sections: sampling, divider, blend
// the per-channel colour divider sets the depth: one quotient bit a stage
// reset clears valid bits and registers: bilinear off, floor 10
// a stalled result freezes the whole pipeline and stalls the input
module bilinear_premult_alpha_blend_rgb565_unit import bpab_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic       bilinear_on_q;
  logic [7:0] alpha_floor_q;
  logic       en;
  pipe_ctl_t  ctl_in, ctl_div, ctl_bl;

  logic                 f_vld;
  logic [2:0][NumW-1:0] f_num;
  side_t                f_side;
  logic                 d_vld;
  logic [2:0][QW-1:0]   d_q;
  logic [2:0]           d_ovf;
  side_t                d_side;

  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;
  assign ctl_in      = '{en: en, vld: in_valid_i};
  assign ctl_div     = '{en: en, vld: f_vld};
  assign ctl_bl      = '{en: en, vld: d_vld};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bilinear_on_q <= 1'b0;
      alpha_floor_q <= ALPHA_FLOOR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BILINEAR_ON: bilinear_on_q <= cfg_data_i[0];
        CFG_ALPHA_FLOOR: alpha_floor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bpab_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_in),
    .word_i (in_word_i),
    .vld_o  (f_vld),
    .num_o  (f_num),
    .side_o (f_side)
  );

  bpab_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_div),
    .num_i  (f_num),
    .side_i (f_side),
    .vld_o  (d_vld),
    .q_o    (d_q),
    .ovf_o  (d_ovf),
    .side_o (d_side)
  );

  bpab_blend u_blend (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl_bl),
    .q_i           (d_q),
    .ovf_i         (d_ovf),
    .side_i        (d_side),
    .bilinear_on_i (bilinear_on_q),
    .alpha_floor_i (alpha_floor_q),
    .vld_o         (out_valid_o),
    .word_o        (out_word_o)
  );

`ifndef SYNTHESIS
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("held output word does not stall input");
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held output word");
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled output word lost");
`endif

endmodule
